// ===== design/smlv_pkg.sv =====
// shared constants, types and command format for the segment label vote block
// no dependencies
package smlv_pkg;

    localparam int NUM_SEGMENTS = 64;
    localparam int NUM_LABELS   = 16;
    localparam int COUNT_WIDTH  = 24;

    localparam int SEG_W     = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int SLOT_W    = $clog2(NUM_LABELS + 1);
    localparam int ADDR_W    = SEG_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    typedef logic [SEG_W-1:0]       t_seg;
    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [FIFO_PTR_W-1:0]  t_fptr;
    typedef logic [FIFO_PTR_W:0]    t_fcnt;

    localparam logic [6:0] SEG_LIMIT  = 7'(NUM_SEGMENTS);
    localparam logic [8:0] LBL_LIMIT  = 9'(NUM_LABELS);
    localparam logic [4:0] LABEL_NONE = 5'h1f;
    localparam t_slot      UNK_SLOT   = t_slot'(NUM_LABELS);
    localparam t_seg       LAST_SEG   = t_seg'(NUM_SEGMENTS - 1);
    localparam t_addr      LAST_ADDR  = t_addr'(MEM_DEPTH - 1);
    localparam t_count     COUNT_MAX  = '1;
    localparam t_fcnt      FIFO_FULL  = t_fcnt'(FIFO_DEPTH);

    typedef struct packed {
        logic  finish;
        logic  bump;
        logic  any;
        t_addr addr;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_EVAL
    } t_state;

endpackage

// ===== design/smlv_if.sv =====
// valid/ready channel interfaces for pixel input and label results
// no dependencies
interface smlv_in_if;
    logic              valid;
    logic              ready;
    logic              operation;
    logic signed [6:0] segment;
    logic signed [4:0] class_label;

    modport source (output valid, output operation, output segment, output class_label,
                    input ready);
    modport sink   (input valid, input operation, input segment, input class_label,
                    output ready);
endinterface

interface smlv_out_if;
    logic              valid;
    logic              ready;
    logic [5:0]        segment_index;
    logic signed [4:0] node_label;
    logic              last;

    modport source (output valid, output segment_index, output node_label, output last,
                    input ready);
    modport sink   (input valid, input segment_index, input node_label, input last,
                    output ready);
endinterface

// ===== design/smlv_front.sv =====
// front end: accepts pixel items and turns them into histogram commands
// depends on smlv_pkg and smlv_if
module smlv_front (
    smlv_in_if.sink        i_pix,
    input  logic           i_fifo_full,
    input  logic           i_clearing,
    output logic           o_push,
    output smlv_pkg::t_cmd o_cmd
);
    import smlv_pkg::*;

    logic [6:0] seg_u;
    logic [4:0] lbl_u;
    logic       seg_ok;
    logic       known;
    logic       in_range;
    t_slot      slot;

    assign seg_u    = i_pix.segment;
    assign lbl_u    = i_pix.class_label;
    assign seg_ok   = ~seg_u[6] && (seg_u < SEG_LIMIT);
    assign known    = ~lbl_u[4];
    assign in_range = ({4'b0, lbl_u} < LBL_LIMIT);
    assign slot     = known ? t_slot'({4'b0, lbl_u}) : UNK_SLOT;

    assign i_pix.ready = ~i_fifo_full && ~i_clearing;
    assign o_push      = i_pix.valid && i_pix.ready;

    always_comb begin
        o_cmd.finish = i_pix.operation;
        o_cmd.any    = ~i_pix.operation && known && in_range;
        o_cmd.bump   = ~i_pix.operation && seg_ok && (~known || in_range);
        o_cmd.addr   = {seg_u[SEG_W-1:0], slot};
    end

endmodule

// ===== design/smlv_cmd_fifo.sv =====
// short command queue between the front end and the histogram engine
// depends on smlv_pkg
module smlv_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smlv_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output smlv_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import smlv_pkg::*;

    t_cmd  r_mem [FIFO_DEPTH];
    t_fptr r_wr_ptr;
    t_fptr r_rd_ptr;
    t_fcnt r_count;
    logic  do_pop;

    assign o_full  = (r_count == FIFO_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + t_fptr'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + t_fptr'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + t_fcnt'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - t_fcnt'(1);
            end
        end
    end

endmodule

// ===== design/smlv_back.sv =====
// back end: histogram memory with read-modify-write pipeline, finish scan
// and result register; depends on smlv_pkg and smlv_if
module smlv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  smlv_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    smlv_out_if.source     o_res
);
    import smlv_pkg::*;

    t_count r_mem [MEM_DEPTH];
    t_count r_rd;

    t_state r_state;
    t_state n_state;

    t_addr  r_clr_addr;
    t_seg   r_seg;
    t_slot  r_slot;
    logic   r_any;

    logic   r_b_valid;
    t_addr  r_b_addr;
    logic   r_wr_valid;
    t_addr  r_wr_addr;
    t_count r_wr_data;

    t_count r_best;
    t_slot  r_best_l;

    logic       r_out_valid;
    logic [5:0] r_out_seg;
    logic [4:0] r_out_lbl;
    logic       r_out_last;

    logic   rd_en;
    t_addr  rd_addr;
    logic   wr_en;
    t_addr  wr_addr;
    t_count wr_data;
    logic   pix_rd;
    logic   out_load;
    t_count cur;
    t_slot  lab;
    logic   winner;

    assign cur    = (r_wr_valid && (r_wr_addr == r_b_addr)) ? r_wr_data : r_rd;
    assign lab    = r_slot - t_slot'(1);
    assign winner = r_any && (r_best >= r_rd);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_cmd_valid && i_cmd.finish) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_slot == UNK_SLOT) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_load) begin
                    n_state = (r_seg == LAST_SEG) ? ST_RUN : ST_SCAN;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath controls
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        pix_rd     = 1'b0;
        o_cmd_pop  = 1'b0;
        o_clearing = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
            end
            ST_RUN: begin
                o_cmd_pop = i_cmd_valid;
                pix_rd    = i_cmd_valid && !i_cmd.finish && i_cmd.bump;
                rd_en     = pix_rd;
                rd_addr   = i_cmd.addr;
                wr_en     = r_b_valid;
                wr_addr   = r_b_addr;
                wr_data   = (cur == COUNT_MAX) ? cur : cur + t_count'(1);
            end
            ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = {r_seg, r_slot};
                wr_en   = 1'b1;
                wr_addr = {r_seg, r_slot};
            end
            ST_EVAL: begin
                out_load = !r_out_valid || o_res.ready;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_addr  <= i_cmd.addr;
        r_wr_addr <= wr_addr;
        r_wr_data <= wr_data;
        if (r_state == ST_SCAN && r_slot != '0) begin
            if (lab == '0 || r_rd > r_best) begin
                r_best   <= r_rd;
                r_best_l <= lab;
            end
        end
        if (out_load) begin
            r_out_seg  <= 6'(r_seg);
            r_out_lbl  <= winner ? 5'(r_best_l) : LABEL_NONE;
            r_out_last <= (r_seg == LAST_SEG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_seg       <= '0;
            r_slot      <= '0;
            r_any       <= 1'b0;
            r_b_valid   <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_b_valid  <= pix_rd;
            r_wr_valid <= wr_en && (r_state == ST_RUN);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
            end
            if (r_state == ST_RUN && i_cmd_valid && i_cmd.any) begin
                r_any <= 1'b1;
            end
            if (r_state == ST_SCAN) begin
                r_slot <= r_slot + t_slot'(1);
            end
            if (out_load) begin
                r_slot <= '0;
                if (r_seg == LAST_SEG) begin
                    r_seg <= '0;
                    r_any <= 1'b0;
                end else begin
                    r_seg <= r_seg + t_seg'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.segment_index = r_out_seg;
    assign o_res.node_label    = r_out_lbl;
    assign o_res.last          = r_out_last;

endmodule

// ===== design/segment_majority_label_vote.sv =====
// top level of the per-segment majority label vote
// depends on smlv_pkg, smlv_if, smlv_front, smlv_cmd_fifo, smlv_back
//
// i_pix carries pixel items (operation 0) with a segment id and a class
// label, or a finish item (operation 1). o_res returns one result per
// segment after a finish, in segment order, last set on the final one.
// Both channels move a transaction when valid and ready are high together.
// Pixel items are taken one per cycle while the command queue is not full:
// each costs one read-modify-write of the one-read one-write histogram
// memory, pipelined with forwarding. A four-entry command queue sits in
// front of the histogram engine. A finish reads every segment's label and
// unknown counts one word a cycle unless o_res stalls, and clears each word
// as it reads it; pixels queue meanwhile until it ends.
// If o_res stalls, the scan holds on the current segment until taken.
// After reset a clearing pass zeroes all 2^(SEG_W + SLOT_W) memory words
// (2048 as configured), with i_pix.ready held low.
module segment_majority_label_vote (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smlv_in_if.sink    i_pix,
    smlv_out_if.source o_res
);
    import smlv_pkg::*;

    logic fifo_full;
    logic clearing;
    logic push;
    t_cmd push_cmd;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    smlv_front u_front (
        .i_pix       (i_pix),
        .i_fifo_full (fifo_full),
        .i_clearing  (clearing),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    smlv_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .o_data  (cmd),
        .i_pop   (cmd_pop)
    );

    smlv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_res       (o_res)
    );

endmodule

// ===== tb/tb_segment_majority_label_vote.sv =====
// self-checking testbench for segment_majority_label_vote: directed table, then random images
// keeps its own per-segment label histograms to predict every result
// depends on smlv_pkg, smlv_if and segment_majority_label_vote from the design
module tb_segment_majority_label_vote;
    timeunit 1ns;
    timeprecision 1ps;

    import smlv_pkg::*;

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int N_DIRECTED     = 20;
    localparam int N_ITEMS        = 130;
    localparam int IDLE_PCT       = 24;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 330;
    localparam int CALM_FROM      = 448;
    localparam int CALM_TO        = 640;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [5:0]        segment_index;
        logic signed [4:0] node_label;
        logic              last;
    } t_vote;

    typedef struct packed {
        logic              op;
        logic signed [6:0] segment;
        logic signed [4:0] class_label;
        logic              pinned;
        logic signed [4:0] pinned_label;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    smlv_in_if  pix_if ();
    smlv_out_if res_if ();

    segment_majority_label_vote i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_if),
        .o_res  (res_if)
    );

    t_count label_hist   [NUM_SEGMENTS][NUM_LABELS];
    t_count unknown_hist [NUM_SEGMENTS];
    logic   label_seen;
    t_vote  expected_votes [$];

    int  n_errors    = 0;
    int  items_sent  = 0;
    int  votes_taken = 0;
    bit  sender_calm = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{OP_FINISH,  7'sd0,  5'sd0, 1'b1, LABEL_NONE},   // nothing seen since reset
        '{OP_PIXEL,  -7'sd1,  5'sd3, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sh40, -5'sd1, 1'b0, 5'sd0},
        '{OP_FINISH,  7'sd0,  5'sd0, 1'b1, 5'sd0},        // label seen, every segment empty
        '{OP_PIXEL,   7'sd0, 5'sd15, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd0, 5'sd15, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd0, -5'sd1, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd0, 5'sh10, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sd63,  5'sd0, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sd63,  5'sd5, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sd63, -5'sd1, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd5, -5'sd1, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd7,  5'sd9, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd7,  5'sd9, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd7,  5'sd2, 1'b0, 5'sd0},
        '{OP_PIXEL,   7'sd7,  5'sd2, 1'b0, 5'sd0},
        '{OP_FINISH, -7'sd1, -5'sd1, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sd10, -5'sd1, 1'b0, 5'sd0},
        '{OP_PIXEL,  7'sd10, -5'sd5, 1'b0, 5'sd0},
        '{OP_FINISH, 7'sd63, 5'sd15, 1'b1, LABEL_NONE}    // only unknown labels
    };

    function automatic void apply_transaction(input t_stim_row row);
        int                seg_i;
        int                lbl_i;
        int                top_lbl;
        t_count            top_cnt;
        logic signed [4:0] winner;
        seg_i = int'(row.segment);
        lbl_i = int'(row.class_label);
        if (row.op == OP_PIXEL) begin
            if (lbl_i >= 0) begin
                if (lbl_i < NUM_LABELS) begin
                    label_seen = 1'b1;
                    if (seg_i >= 0 && seg_i < NUM_SEGMENTS) begin
                        if (label_hist[seg_i][lbl_i] != COUNT_MAX)
                            label_hist[seg_i][lbl_i]++;
                    end
                end
            end else if (seg_i >= 0 && seg_i < NUM_SEGMENTS) begin
                if (unknown_hist[seg_i] != COUNT_MAX)
                    unknown_hist[seg_i]++;
            end
        end else begin
            for (int s = 0; s < NUM_SEGMENTS; s++) begin
                winner = LABEL_NONE;
                if (label_seen) begin
                    top_lbl = 0;
                    top_cnt = label_hist[s][0];
                    for (int l = 1; l < NUM_LABELS; l++) begin
                        if (label_hist[s][l] > top_cnt) begin
                            top_cnt = label_hist[s][l];
                            top_lbl = l;
                        end
                    end
                    if (top_cnt >= unknown_hist[s])
                        winner = 5'(top_lbl);
                end
                if (row.pinned)
                    winner = row.pinned_label;
                expected_votes.push_back(t_vote'{6'(s), winner, s == NUM_SEGMENTS - 1});
                for (int l = 0; l < NUM_LABELS; l++)
                    label_hist[s][l] = '0;
                unknown_hist[s] = '0;
            end
            label_seen = 1'b0;
        end
    endfunction

    task automatic offer(input t_stim_row row);
        while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.operation   <= row.op;
        pix_if.segment     <= row.segment;
        pix_if.class_label <= row.class_label;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        apply_transaction(row);
        items_sent++;
    endtask

    task automatic send_random_image();
        logic [5:0]        hot_seg [3];
        logic signed [4:0] hot_lbl [2];
        t_stim_row         row;
        int                n_pix;
        bit                only_unknown;
        foreach (hot_seg[i])
            hot_seg[i] = 6'($urandom_range(0, NUM_SEGMENTS - 1));
        foreach (hot_lbl[i])
            hot_lbl[i] = 5'($urandom_range(0, NUM_LABELS - 1));
        n_pix        = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 24);
        only_unknown = ($urandom_range(7) == 0);
        for (int k = 0; k < n_pix; k++) begin
            row    = '0;
            row.op = OP_PIXEL;
            case ($urandom_range(9))
                0:       row.segment = 7'($urandom);
                1:       row.segment = 7'($urandom_range(0, NUM_SEGMENTS - 1));
                default: row.segment = 7'(hot_seg[$urandom_range(2)]);
            endcase
            if (only_unknown) begin
                row.class_label = 5'(-int'($urandom_range(1, 16)));
            end else begin
                case ($urandom_range(9))
                    0, 1:    row.class_label = -5'sd1;
                    2:       row.class_label = 5'($urandom);
                    default: row.class_label = hot_lbl[$urandom_range(1)];
                endcase
            end
            offer(row);
        end
        row             = '0;
        row.op          = OP_FINISH;
        row.segment     = 7'($urandom);
        row.class_label = 5'($urandom);
        offer(row);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int image_no;
        image_no           = 0;
        pix_if.valid       = 1'b0;
        pix_if.operation   = OP_PIXEL;
        pix_if.segment     = '0;
        pix_if.class_label = '0;
        label_seen         = 1'b0;
        foreach (label_hist[s, l])
            label_hist[s][l] = '0;
        foreach (unknown_hist[s])
            unknown_hist[s] = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer(directed_rows[r]);

        while (items_sent < N_ITEMS) begin
            image_no++;
            sender_calm = (image_no == 2 || image_no == 3);
            // let the block drain completely before this image
            if (image_no == 5) begin
                pix_if.valid <= 1'b0;
                @(posedge i_clk);
                while (expected_votes.size() != 0) @(posedge i_clk);
            end
            send_random_image();
        end

        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_votes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_segment_majority_label_vote: clean");
        else
            $display("tb_segment_majority_label_vote: errors");
        $finish;
    end

    initial begin
        int    hold_left;
        bit    held;
        t_vote got;
        t_vote want;
        hold_left    = 0;
        held         = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = t_vote'{res_if.segment_index, res_if.node_label, res_if.last};
                if (expected_votes.size() == 0) begin
                    $display("%0t: unexpected transaction: segment %0d label %0d last %0b",
                             $time, got.segment_index, got.node_label, got.last);
                    n_errors++;
                end else begin
                    want = expected_votes.pop_front();
                    if (got !== want) begin
                        $display({"%0t: expected segment %0d label %0d last %0b, ",
                                  "actual segment %0d label %0d last %0b"},
                                 $time, want.segment_index, want.node_label, want.last,
                                 got.segment_index, got.node_label, got.last);
                        n_errors++;
                    end
                end
                votes_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!held && votes_taken >= HOLD_AT_RESULT) begin
                held         = 1;
                hold_left    = LONG_HOLD - 1;
                res_if.ready <= 1'b0;
            end else if (votes_taken >= CALM_FROM && votes_taken < CALM_TO) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("tb_segment_majority_label_vote: errors");
        $finish;
    end

endmodule

// ===== segment_majority_label_vote.f =====
design/smlv_pkg.sv
design/smlv_if.sv
design/smlv_front.sv
design/smlv_cmd_fifo.sv
design/smlv_back.sv
design/segment_majority_label_vote.sv
tb/tb_segment_majority_label_vote.sv
